FILE: sv/rgbhsv_pkg.sv
`default_nettype none

package rgbhsv_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int FRACTION_BITS = 16;

    localparam int PIXEL_BITS = 3 * CHANNEL_BITS;
    localparam int IN_TDATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int RESULT_BITS = 2 * FRACTION_BITS + CHANNEL_BITS;
    localparam int OUT_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

    localparam int HUE_DEN_BITS = CHANNEL_BITS + 3;
    localparam int DIV_STEPS = FRACTION_BITS + 1;

    localparam logic [FRACTION_BITS-1:0] HUE_OFFSET_RED = '0;
    localparam logic [FRACTION_BITS-1:0] HUE_OFFSET_GREEN =
        FRACTION_BITS'((2 * (1 << FRACTION_BITS) + 3) / 6);
    localparam logic [FRACTION_BITS-1:0] HUE_OFFSET_BLUE =
        FRACTION_BITS'((4 * (1 << FRACTION_BITS) + 3) / 6);

    typedef logic [1:0] sector_t;

    localparam sector_t SECTOR_RED = 2'd0;
    localparam sector_t SECTOR_GREEN = 2'd1;
    localparam sector_t SECTOR_BLUE = 2'd2;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] blue;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] brightness;
        sector_t                 sector;
        logic                    neg;
        logic                    sat_zero;
        logic                    hue_zero;
    } side_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] sat_num;
        logic [CHANNEL_BITS-1:0] sat_den;
        logic [CHANNEL_BITS-1:0] hue_num;
        logic [HUE_DEN_BITS-1:0] hue_den;
        side_t                   side;
    } div_in_t;

    typedef struct packed {
        logic [FRACTION_BITS:0]  sat_q;
        logic [FRACTION_BITS:0]  hue_q;
        logic [HUE_DEN_BITS-1:0] hue_rem;
        side_t                   side;
    } div_out_t;

    function automatic logic [FRACTION_BITS-1:0] hue_offset(input sector_t sector);
        logic [FRACTION_BITS-1:0] offset;
        case (sector)
            SECTOR_RED:   offset = HUE_OFFSET_RED;
            SECTOR_GREEN: offset = HUE_OFFSET_GREEN;
            SECTOR_BLUE:  offset = HUE_OFFSET_BLUE;
            default:      offset = HUE_OFFSET_RED;
        endcase
        return offset;
    endfunction

endpackage

`default_nettype wire

FILE: sv/rgb_to_hsv_converter.sv
`default_nettype none

// RGB to HSV converter for one pixel per clock. Each item carries red, green and blue;
// the result item carries hue (a 16-bit fraction of a full turn), saturation (an
// unsigned 0.16 fraction that saturates at all ones) and brightness (the largest
// channel). Black and gray pixels give a hue of zero. The block accepts a new item
// every cycle while the output is not stalled. Each item passes through the front
// registers that find maximum, minimum and sector and then form the numerators and
// denominators, a one-bit-per-stage divider that forms both quotients side by side,
// and a back register for the final sign fix, sector offset and saturation. A stall
// on the output holds the whole pipeline; a one-item skid register at the input keeps
// s_tready a registered signal.
module rgb_to_hsv_converter (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // red, green, blue
    input  wire logic [rgbhsv_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // hue, saturation, brightness
    output logic [rgbhsv_pkg::OUT_TDATA_BITS-1:0]       m_tdata
);

    logic                                  en;
    logic                                  pix_valid;
    rgbhsv_pkg::pixel_t                    pixel;
    logic                                  front_valid;
    rgbhsv_pkg::div_in_t                   div_in;
    logic                                  div_valid;
    rgbhsv_pkg::div_out_t                  div_out;
    logic [rgbhsv_pkg::FRACTION_BITS-1:0]  hue;
    logic [rgbhsv_pkg::FRACTION_BITS-1:0]  saturation;
    logic [rgbhsv_pkg::CHANNEL_BITS-1:0]   brightness;

    assign en = !m_tvalid || m_tready;

    rgbhsv_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .en       (en),
        .valid    (pix_valid),
        .pixel    (pixel)
    );

    rgbhsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix_valid),
        .pixel     (pixel),
        .out_valid (front_valid),
        .div_in    (div_in)
    );

    rgbhsv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .div_in    (div_in),
        .out_valid (div_valid),
        .div_out   (div_out)
    );

    rgbhsv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (div_valid),
        .div_out    (div_out),
        .out_valid  (m_tvalid),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    assign m_tdata = rgbhsv_pkg::OUT_TDATA_BITS'({brightness, saturation, hue});

endmodule

`default_nettype wire

FILE: sv/rgbhsv_skid.sv
`default_nettype none

module rgbhsv_skid (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [rgbhsv_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    input  wire logic                                   en,
    output logic                                        valid,
    output rgbhsv_pkg::pixel_t                          pixel
);

    logic                skid_valid_reg;
    logic                skid_valid_next;
    rgbhsv_pkg::pixel_t  skid_pixel_reg;
    rgbhsv_pkg::pixel_t  in_pixel;

    assign in_pixel = rgbhsv_pkg::pixel_t'(s_tdata[rgbhsv_pkg::PIXEL_BITS-1:0]);

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg && en)
        begin
            skid_valid_next = 1'b0;
        end
        else if (!skid_valid_reg && s_tvalid && !en)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_pixel_reg <= in_pixel;
        end
    end

    assign s_tready = !skid_valid_reg;
    assign valid = skid_valid_reg || s_tvalid;
    assign pixel = skid_valid_reg ? skid_pixel_reg : in_pixel;

endmodule

`default_nettype wire

FILE: sv/rgbhsv_front.sv
`default_nettype none

module rgbhsv_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire rgbhsv_pkg::pixel_t   pixel,
    output logic                      out_valid,
    output rgbhsv_pkg::div_in_t       div_in
);

    localparam int C = rgbhsv_pkg::CHANNEL_BITS;

    logic                 a_valid_reg;
    logic [C-1:0]         a_red_reg;
    logic [C-1:0]         a_green_reg;
    logic [C-1:0]         a_blue_reg;
    logic [C-1:0]         a_max_reg;
    logic [C-1:0]         a_min_reg;
    rgbhsv_pkg::sector_t  a_sector_reg;

    logic [C-1:0]         a_max_next;
    logic [C-1:0]         a_min_next;
    rgbhsv_pkg::sector_t  a_sector_next;

    logic                 b_valid_reg;
    rgbhsv_pkg::div_in_t  b_div_reg;
    rgbhsv_pkg::div_in_t  b_div_next;

    logic [C-1:0]         diff;
    logic [C:0]           num;
    logic [C:0]           num_abs;

    always_comb
    begin
        a_max_next = pixel.red;
        if (pixel.green > a_max_next)
        begin
            a_max_next = pixel.green;
        end
        if (pixel.blue > a_max_next)
        begin
            a_max_next = pixel.blue;
        end
        a_min_next = pixel.red;
        if (pixel.green < a_min_next)
        begin
            a_min_next = pixel.green;
        end
        if (pixel.blue < a_min_next)
        begin
            a_min_next = pixel.blue;
        end
        if (pixel.red == a_max_next)
        begin
            a_sector_next = rgbhsv_pkg::SECTOR_RED;
        end
        else if (pixel.green == a_max_next)
        begin
            a_sector_next = rgbhsv_pkg::SECTOR_GREEN;
        end
        else
        begin
            a_sector_next = rgbhsv_pkg::SECTOR_BLUE;
        end
    end

    always_comb
    begin
        diff = a_max_reg - a_min_reg;
        case (a_sector_reg)
            rgbhsv_pkg::SECTOR_RED:   num = {1'b0, a_green_reg} - {1'b0, a_blue_reg};
            rgbhsv_pkg::SECTOR_GREEN: num = {1'b0, a_blue_reg} - {1'b0, a_red_reg};
            rgbhsv_pkg::SECTOR_BLUE:  num = {1'b0, a_red_reg} - {1'b0, a_green_reg};
            default:                  num = '0;
        endcase
        num_abs = num[C] ? (~num + 1'b1) : num;

        b_div_next.sat_num = diff;
        b_div_next.sat_den = a_max_reg;
        b_div_next.hue_num = num_abs[C-1:0];
        b_div_next.hue_den = ({3'b000, diff} << 2) + ({3'b000, diff} << 1);
        b_div_next.side.brightness = a_max_reg;
        b_div_next.side.sector = a_sector_reg;
        b_div_next.side.neg = num[C];
        b_div_next.side.sat_zero = (a_max_reg == '0);
        b_div_next.side.hue_zero = (diff == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_red_reg <= pixel.red;
            a_green_reg <= pixel.green;
            a_blue_reg <= pixel.blue;
            a_max_reg <= a_max_next;
            a_min_reg <= a_min_next;
            a_sector_reg <= a_sector_next;
            b_div_reg <= b_div_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign div_in = b_div_reg;

endmodule

`default_nettype wire

FILE: sv/rgbhsv_div.sv
`default_nettype none

module rgbhsv_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire rgbhsv_pkg::div_in_t  div_in,
    output logic                      out_valid,
    output rgbhsv_pkg::div_out_t      div_out
);

    localparam int C = rgbhsv_pkg::CHANNEL_BITS;
    localparam int F = rgbhsv_pkg::FRACTION_BITS;
    localparam int HD = rgbhsv_pkg::HUE_DEN_BITS;
    localparam int STEPS = rgbhsv_pkg::DIV_STEPS;

    logic                 valid_reg   [0:STEPS-1];
    logic [C-1:0]         sat_rem_reg [0:STEPS-1];
    logic [C-1:0]         sat_den_reg [0:STEPS-1];
    logic [F:0]           sat_q_reg   [0:STEPS-1];
    logic [HD-1:0]        hue_rem_reg [0:STEPS-1];
    logic [HD-1:0]        hue_den_reg [0:STEPS-1];
    logic [F:0]           hue_q_reg   [0:STEPS-1];
    rgbhsv_pkg::side_t    side_reg    [0:STEPS-1];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic                valid_in;
        logic [C-1:0]        sat_rem_in;
        logic [C-1:0]        sat_den_in;
        logic [F:0]          sat_q_in;
        logic [HD-1:0]       hue_rem_in;
        logic [HD-1:0]       hue_den_in;
        logic [F:0]          hue_q_in;
        rgbhsv_pkg::side_t   side_in;
        logic [C:0]          sat_trial;
        logic [C:0]          sat_sub;
        logic                sat_ge;
        logic [HD:0]         hue_trial;
        logic [HD:0]         hue_sub;
        logic                hue_ge;
        logic [C-1:0]        sat_rem_next;
        logic [HD-1:0]       hue_rem_next;

        if (k == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign sat_rem_in = div_in.sat_num;
            assign sat_den_in = div_in.sat_den;
            assign sat_q_in = '0;
            assign hue_rem_in = HD'(div_in.hue_num);
            assign hue_den_in = div_in.hue_den;
            assign hue_q_in = '0;
            assign side_in = div_in.side;
            assign sat_trial = {1'b0, sat_rem_in};
            assign hue_trial = {1'b0, hue_rem_in};
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[k-1];
            assign sat_rem_in = sat_rem_reg[k-1];
            assign sat_den_in = sat_den_reg[k-1];
            assign sat_q_in = sat_q_reg[k-1];
            assign hue_rem_in = hue_rem_reg[k-1];
            assign hue_den_in = hue_den_reg[k-1];
            assign hue_q_in = hue_q_reg[k-1];
            assign side_in = side_reg[k-1];
            assign sat_trial = {sat_rem_in, 1'b0};
            assign hue_trial = {hue_rem_in, 1'b0};
        end

        assign sat_sub = sat_trial - {1'b0, sat_den_in};
        assign sat_ge = (sat_trial >= {1'b0, sat_den_in});
        assign sat_rem_next = sat_ge ? sat_sub[C-1:0] : sat_trial[C-1:0];
        assign hue_sub = hue_trial - {1'b0, hue_den_in};
        assign hue_ge = (hue_trial >= {1'b0, hue_den_in});
        assign hue_rem_next = hue_ge ? hue_sub[HD-1:0] : hue_trial[HD-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sat_rem_reg[k] <= sat_rem_next;
                sat_den_reg[k] <= sat_den_in;
                sat_q_reg[k] <= {sat_q_in[F-1:0], sat_ge};
                hue_rem_reg[k] <= hue_rem_next;
                hue_den_reg[k] <= hue_den_in;
                hue_q_reg[k] <= {hue_q_in[F-1:0], hue_ge};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign div_out.sat_q = sat_q_reg[STEPS-1];
    assign div_out.hue_q = hue_q_reg[STEPS-1];
    assign div_out.hue_rem = hue_rem_reg[STEPS-1];
    assign div_out.side = side_reg[STEPS-1];

endmodule

`default_nettype wire

FILE: sv/rgbhsv_back.sv
`default_nettype none

module rgbhsv_back (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire logic                                  in_valid,
    input  wire rgbhsv_pkg::div_out_t                  div_out,
    output logic                                       out_valid,
    output logic [rgbhsv_pkg::FRACTION_BITS-1:0]       hue,
    output logic [rgbhsv_pkg::FRACTION_BITS-1:0]       saturation,
    output logic [rgbhsv_pkg::CHANNEL_BITS-1:0]        brightness
);

    localparam int F = rgbhsv_pkg::FRACTION_BITS;

    logic          valid_reg;
    logic [F-1:0]  hue_reg;
    logic [F-1:0]  hue_next;
    logic [F-1:0]  sat_reg;
    logic [F-1:0]  sat_next;
    logic [rgbhsv_pkg::CHANNEL_BITS-1:0] brightness_reg;

    logic [F-1:0]  mag;
    logic [F-1:0]  step;

    always_comb
    begin
        if (div_out.side.sat_zero)
        begin
            sat_next = '0;
        end
        else if (div_out.sat_q[F])
        begin
            sat_next = '1;
        end
        else
        begin
            sat_next = div_out.sat_q[F-1:0];
        end

        mag = div_out.hue_q[F-1:0]
            + F'(div_out.side.neg && (div_out.hue_rem != '0));
        step = div_out.side.neg ? (~mag + 1'b1) : mag;
        if (div_out.side.hue_zero)
        begin
            hue_next = '0;
        end
        else
        begin
            hue_next = rgbhsv_pkg::hue_offset(div_out.side.sector) + step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            brightness_reg <= div_out.side.brightness;
        end
    end

    assign out_valid = valid_reg;
    assign hue = hue_reg;
    assign saturation = sat_reg;
    assign brightness = brightness_reg;

endmodule

`default_nettype wire

FILE: tb/rgb_to_hsv_converter_tb.sv
`timescale 1ns / 1ps

module rgb_to_hsv_converter_tb;

    localparam int CB = rgbhsv_pkg::CHANNEL_BITS;
    localparam int FB = rgbhsv_pkg::FRACTION_BITS;
    localparam int IN_BITS = rgbhsv_pkg::IN_TDATA_BITS;
    localparam int OUT_BITS = rgbhsv_pkg::OUT_TDATA_BITS;
    localparam longint FRAC_MAX = (longint'(1) << FB) - 1;
    localparam int DIRECTED_ROWS = 24;
    localparam int HOLD_PIXELS = 120;
    localparam int RANDOM_PIXELS = 1206;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS = 40;
    localparam longint TIMEOUT_NS = 5_000_000;

    typedef struct packed {
        logic [CB-1:0] bright;
        logic [FB-1:0] sat;
        logic [FB-1:0] hue;
    } hsv_t;

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
        logic          known;
        logic [FB-1:0] hue;
        logic [FB-1:0] sat;
        logic [CB-1:0] bright;
    } pixel_case_t;

    // Rows marked known carry the result that follows directly from the pixel.
    localparam pixel_case_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, 16'd0,     16'd0,     8'd0},
        '{8'd255, 8'd255, 8'd255, 1'b1, 16'd0,     16'd0,     8'd255},
        '{8'd128, 8'd128, 8'd128, 1'b1, 16'd0,     16'd0,     8'd128},
        '{8'd1,   8'd1,   8'd1,   1'b1, 16'd0,     16'd0,     8'd1},
        '{8'd255, 8'd0,   8'd0,   1'b1, 16'd0,     16'd65535, 8'd255},
        '{8'd0,   8'd255, 8'd0,   1'b1, 16'd21845, 16'd65535, 8'd255},
        '{8'd0,   8'd0,   8'd255, 1'b1, 16'd43691, 16'd65535, 8'd255},
        '{8'd1,   8'd0,   8'd0,   1'b1, 16'd0,     16'd65535, 8'd1},
        '{8'd255, 8'd255, 8'd0,   1'b0, 16'd0,     16'd0,     8'd0},
        '{8'd0,   8'd255, 8'd255, 1'b0, 16'd0,     16'd0,     8'd0},
        '{8'd255, 8'd0,   8'd255, 1'b0, 16'd0,     16'd0,     8'd0},
        '{8'd255, 8'd0,   8'd1,   1'b0, 16'd0,     16'd0,     8'd0},
        '{8'd200, 8'd100, 8'd150, 1'b0, 16'd0,     16'd0,     8'd0},
        '{8'd100, 8'd200, 8'd50,  1'b0, 16'd0,     16'd0,     8'd0},
        '{8'd50,  8'd100, 8'd200, 1'b0, 16'd0,     16'd0,     8'd0},
        '{8'd170, 8'd85,  8'd0,   1'b0, 16'd0,     16'd0,     8'd0},
        '{8'd85,  8'd170, 8'd255, 1'b0, 16'd0,     16'd0,     8'd0},
        '{8'd254, 8'd127, 8'd1,   1'b0, 16'd0,     16'd0,     8'd0},
        '{8'd1,   8'd254, 8'd128, 1'b0, 16'd0,     16'd0,     8'd0},
        '{8'd128, 8'd127, 8'd126, 1'b0, 16'd0,     16'd0,     8'd0},
        '{8'd255, 8'd254, 8'd255, 1'b0, 16'd0,     16'd0,     8'd0},
        '{8'd0,   8'd1,   8'd1,   1'b0, 16'd0,     16'd0,     8'd0},
        '{8'd128, 8'd0,   8'd0,   1'b0, 16'd0,     16'd0,     8'd0},
        '{8'd255, 8'd128, 8'd0,   1'b0, 16'd0,     16'd0,     8'd0}
    };

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_BITS-1:0] m_tdata;

    hsv_t expected_hsv_q[$];
    int   mismatches = 0;
    bit   hold_req = 1'b0;
    bit   hold_used = 1'b0;

    rgb_to_hsv_converter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic hsv_t predict_hsv(input logic [CB-1:0] r, g, b);
        longint ri, gi, bi, mx, mn, diff, num, den, step, ratio;
        rgbhsv_pkg::sector_t sector;
        hsv_t res;
        ri = r;
        gi = g;
        bi = b;
        mx = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        mn = ri;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        diff = mx - mn;
        res = '0;
        res.bright = mx[CB-1:0];
        if (mx != 0)
        begin
            ratio = (diff << FB) / mx;
            res.sat = (ratio > FRAC_MAX) ? FRAC_MAX[FB-1:0] : ratio[FB-1:0];
            if (diff != 0)
            begin
                if (ri == mx)
                begin
                    sector = rgbhsv_pkg::SECTOR_RED;
                    num = gi - bi;
                end
                else if (gi == mx)
                begin
                    sector = rgbhsv_pkg::SECTOR_GREEN;
                    num = bi - ri;
                end
                else
                begin
                    sector = rgbhsv_pkg::SECTOR_BLUE;
                    num = ri - gi;
                end
                den = 6 * diff;
                // The hue step rounds toward minus infinity.
                if (num >= 0)
                    step = (num << FB) / den;
                else
                    step = -((((-num) << FB) + den - 1) / den);
                res.hue = FB'((2 * longint'(sector) * (longint'(1) << FB) + 3) / 6 + step);
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic send_pixel(input logic [CB-1:0] r, g, b, input bit known, input hsv_t typed);
        s_tvalid <= 1'b1;
        s_tdata <= IN_BITS'({b, g, r});
        do @(posedge clk); while (!s_tready);
        expected_hsv_q.push_back(known ? typed : predict_hsv(r, g, b));
    endtask

    function automatic logic [CB-1:0] pick_channel();
        logic [CB-1:0] value;
        case ($urandom_range(0, 7))
            0:       value = '0;
            1:       value = '1;
            2:       value = CB'($urandom_range(0, 3));
            3:       value = CB'($urandom_range((1 << CB) - 4, (1 << CB) - 1));
            default: value = CB'($urandom_range(0, (1 << CB) - 1));
        endcase
        return value;
    endfunction

    task automatic send_random_pixel();
        logic [CB-1:0] r, g, b;
        r = pick_channel();
        g = pick_channel();
        b = pick_channel();
        case ($urandom_range(0, 9))
            0:
            begin
                g = r;
                b = r;
            end
            1: g = r;
            2: b = g;
            3: b = r;
            default: ;
        endcase
        send_pixel(r, g, b, 1'b0, '0);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_hsv_q.size() != 0) @(posedge clk);
    endtask

    task automatic send_random_bursts(input int count);
        int left, burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 48);
            if (burst > left) burst = left;
            repeat (burst) send_random_pixel();
            left -= burst;
            idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        end
    endtask

    always @(posedge clk)
    begin
        hsv_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = hsv_t'(m_tdata[$bits(hsv_t)-1:0]);
            if (expected_hsv_q.size() == 0)
                report_mismatch("result with nothing pending, hue", got.hue, 0);
            else
            begin
                want = expected_hsv_q.pop_front();
                if (got.hue !== want.hue) report_mismatch("hue", got.hue, want.hue);
                if (got.sat !== want.sat) report_mismatch("saturation", got.sat, want.sat);
                if (got.bright !== want.bright)
                    report_mismatch("brightness", got.bright, want.bright);
            end
        end
    end

    // Output side: stretches of different stall patterns, plus one long hold-off.
    initial
    begin
        int mode, span;
        mode = 0;
        span = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_used)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_used = 1'b1;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(16, 160);
                end
                span--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 2) == 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        hsv_t typed;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            typed.hue = DIRECTED[i].hue;
            typed.sat = DIRECTED[i].sat;
            typed.bright = DIRECTED[i].bright;
            send_pixel(DIRECTED[i].red, DIRECTED[i].green, DIRECTED[i].blue,
                       DIRECTED[i].known, typed);
            idle_for($urandom_range(0, 2));
        end
        wait_drained();

        // The output holds off while pixels keep coming, so the pipeline fills up.
        hold_req = 1'b1;
        repeat (HOLD_PIXELS) send_random_pixel();

        send_random_bursts(RANDOM_PIXELS / 2);
        wait_drained();
        send_random_bursts(RANDOM_PIXELS - RANDOM_PIXELS / 2);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
